FILE: rtl/core/phct_pkg.sv
// Package for the packet header parser / corner-turn block.
// Holds widths, result kinds, register indexes, control types and the result word.
// No dependencies.
package phct_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned LEN_W       = 15;
    localparam int unsigned BIDX_W      = 10;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned CH_W        = 12;
    localparam int unsigned SUB_W       = 8;
    localparam int unsigned ADDR_OUT_W  = 24;
    localparam int unsigned PPB_W       = 11;
    localparam int unsigned CNT_W       = 12;
    localparam int unsigned ADDR_BITS_DEF = 24;

    // Full width of base + chan*ppb*spp + sample before wrapping.
    localparam int unsigned SUM_W       = 36;
    localparam int unsigned P1_W        = CNT_W + PPB_W;
    localparam int unsigned P2_W        = P1_W + CNT_W;
    localparam int unsigned BASE_W      = BIDX_W + CNT_W;

    // Restoring divider: (length-16)/4 is 13 bits.
    localparam int unsigned DIVIDEND_W  = LEN_W - 2;
    localparam int unsigned DIV_STEPS   = DIVIDEND_W;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [CNT_W-1:0] SAT12  = '1;

    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = CH_W;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PPB        = 1'd1;

    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PLACED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SURPLUS = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic                  header_valid;
        logic [CH_W-1:0]       channels;
        logic [SUB_W-1:0]      subpackets;
        logic [WORD_W-1:0]     timestamp;
        logic [WORD_W-1:0]     sequence_res;
        logic [WORD_W-1:0]     sample;
        logic [ADDR_OUT_W-1:0] address;
        logic                  last_of_packet;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic take;      // word accepted this cycle
        logic mul_step;  // second product of the address
        logic sum_step;  // final address add
        logic emit;      // move staged result to output register
    } t_cmd;

    typedef struct packed {
        logic pos_first;   // next word is header word 0
        logic pos_header;  // next word is a header word
        logic hdr_result;  // next word gives a header result
        logic div_busy;
        logic last_word;   // staged word was the packet's final word
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/core/phct_word_if.sv
// Input channel: one packet word with its side fields.
// Depends on phct_pkg.
interface phct_word_if;
    logic                          valid;
    logic                          ready;
    logic [phct_pkg::WORD_W-1:0]   word;
    logic [phct_pkg::LEN_W-1:0]    packet_length;
    logic [phct_pkg::BIDX_W-1:0]   block_index;
    logic                          last;

    modport source (output valid, output word, output packet_length, output block_index,
                    output last, input ready);
    modport sink (input valid, input word, input packet_length, input block_index,
                  input last, output ready);
endinterface

FILE: rtl/core/phct_res_if.sv
// Output channel: one header summary or payload placement word.
// Depends on phct_pkg.
interface phct_res_if;
    logic                              valid;
    logic                              ready;
    logic [phct_pkg::KIND_W-1:0]       kind;
    logic                              header_valid;
    logic [phct_pkg::CH_W-1:0]         channels;
    logic [phct_pkg::SUB_W-1:0]        subpackets;
    logic [phct_pkg::WORD_W-1:0]       timestamp;
    logic [phct_pkg::WORD_W-1:0]       sequence_res;
    logic [phct_pkg::WORD_W-1:0]       sample;
    logic [phct_pkg::ADDR_OUT_W-1:0]   address;
    logic                              last_of_packet;

    modport source (output valid, output kind, output header_valid, output channels,
                    output subpackets, output timestamp, output sequence_res, output sample,
                    output address, output last_of_packet, input ready);
    modport sink (input valid, input kind, input header_valid, input channels,
                  input subpackets, input timestamp, input sequence_res, input sample,
                  input address, input last_of_packet, output ready);
endinterface

FILE: rtl/core/phct_dpath.sv
// Datapath: config registers, header capture, spp divider, corner-turn address
// products, staged result and output register. Depends on phct_pkg.
module phct_dpath #(
    parameter int unsigned ADDR_BITS = phct_pkg::ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  phct_pkg::t_cmd                    i_cmd,
    output phct_pkg::t_stat                   o_stat,
    input  logic [phct_pkg::WORD_W-1:0]       i_word,
    input  logic [phct_pkg::LEN_W-1:0]        i_len,
    input  logic [phct_pkg::BIDX_W-1:0]       i_bidx,
    input  logic                              i_last,
    input  logic                              i_cfg_we,
    input  logic [phct_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [phct_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output phct_pkg::t_result                 o_out
);

    localparam int unsigned AW = (ADDR_BITS < phct_pkg::SUM_W) ? ADDR_BITS : phct_pkg::SUM_W;

    // config
    logic [phct_pkg::CH_W-1:0]   r_chan_count;
    logic [phct_pkg::PPB_W-1:0]  r_ppb;

    // packet state
    logic [phct_pkg::CNT_W-1:0]  r_wpos, n_wpos;
    logic [phct_pkg::CH_W-1:0]   r_cap_ch, n_cap_ch;
    logic [phct_pkg::SUB_W-1:0]  r_cap_sub, n_cap_sub;
    logic [phct_pkg::WORD_W-1:0] r_cap_ts, n_cap_ts;
    logic [phct_pkg::CNT_W-1:0]  r_spp;
    logic [phct_pkg::CNT_W-1:0]  r_cc, n_cc;
    logic [phct_pkg::CNT_W-1:0]  r_sc, n_sc;
    logic [phct_pkg::BASE_W-1:0] r_base;

    // divider
    logic [phct_pkg::DIV_CNT_W-1:0]  r_div_cnt;
    logic [phct_pkg::DIVIDEND_W-1:0] r_quo, n_quo;
    logic [phct_pkg::CH_W-1:0]       r_rem, r_den;
    logic [phct_pkg::CH_W:0]         rem_sh, rem_sub;
    logic                            div_ge;
    logic [phct_pkg::LEN_W-1:0]      len_body;
    logic                            div_trivial;

    // address
    logic [phct_pkg::P1_W-1:0]   r_p1;
    logic [phct_pkg::P2_W-1:0]   r_p2;
    logic [phct_pkg::CNT_W-1:0]  r_samp;
    logic [phct_pkg::SUM_W-1:0]  addr_sum, addr_wrap;

    // header check
    logic [phct_pkg::CH_W+phct_pkg::SUB_W-1:0]   cs_prod;
    logic [phct_pkg::CH_W+phct_pkg::SUB_W+2:0]   need_len;
    logic                                        hdr_ok;

    logic                        pos_first, pos_header, pos_three;
    logic                        chan_wrap;
    phct_pkg::t_result           r_res, n_res;
    phct_pkg::t_result           r_out;
    logic                        r_out_valid;

    assign pos_first  = (r_wpos == '0);
    assign pos_header = (r_wpos[phct_pkg::CNT_W-1:2] == '0);
    assign pos_three  = (r_wpos == phct_pkg::CNT_W'(3));

    // header capture
    always_comb begin
        n_cap_ch  = r_cap_ch;
        n_cap_sub = r_cap_sub;
        n_cap_ts  = r_cap_ts;
        if (pos_first) begin
            n_cap_ch  = {i_word[23:20], 8'h00};
            n_cap_sub = '0;
            n_cap_ts  = '0;
        end else if (r_wpos == phct_pkg::CNT_W'(1)) begin
            n_cap_ch  = {r_cap_ch[11:8], i_word[23:16]};
            n_cap_sub = i_word[31:24];
        end else if (r_wpos == phct_pkg::CNT_W'(2)) begin
            n_cap_ts  = i_word;
        end
    end

    assign cs_prod  = (phct_pkg::CH_W+phct_pkg::SUB_W)'(n_cap_ch)
                    * (phct_pkg::CH_W+phct_pkg::SUB_W)'(n_cap_sub);
    assign need_len = {1'b0, cs_prod, 2'b00} + (phct_pkg::CH_W+phct_pkg::SUB_W+3)'(16);
    assign hdr_ok   = pos_three && ((phct_pkg::CH_W+phct_pkg::SUB_W+3)'(i_len) == need_len);

    // staged result for the word being taken
    always_comb begin
        n_res = '0;
        n_res.last_of_packet = i_last;
        if (pos_header) begin
            n_res.kind         = phct_pkg::KIND_HEADER;
            n_res.header_valid = hdr_ok;
            n_res.channels     = n_cap_ch;
            n_res.subpackets   = n_cap_sub;
            n_res.timestamp    = n_cap_ts;
            n_res.sequence_res = hdr_ok ? i_word : '0;
        end else begin
            n_res.kind   = (r_sc < r_spp) ? phct_pkg::KIND_PLACED : phct_pkg::KIND_SURPLUS;
            n_res.sample = i_word;
        end
    end

    // channel / sample counters, channel wraps at the live chan_count
    assign chan_wrap = ({1'b0, r_cc} + 13'd1) >= {1'b0, r_chan_count};
    always_comb begin
        n_cc = r_cc + 1'b1;
        n_sc = r_sc;
        if (chan_wrap) begin
            n_cc = '0;
            if (r_sc != phct_pkg::SAT12) begin
                n_sc = r_sc + 1'b1;
            end
        end
    end

    always_comb begin
        if (i_last) begin
            n_wpos = '0;
        end else if (r_wpos != phct_pkg::SAT12) begin
            n_wpos = r_wpos + 1'b1;
        end else begin
            n_wpos = r_wpos;
        end
    end

    // divider step
    assign len_body    = i_len - phct_pkg::LEN_W'(16);
    assign div_trivial = (i_len < phct_pkg::LEN_W'(16)) || (r_chan_count == '0);
    assign rem_sh      = {r_rem, r_quo[phct_pkg::DIVIDEND_W-1]};
    assign div_ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub     = rem_sh - {1'b0, r_den};
    assign n_quo       = {r_quo[phct_pkg::DIVIDEND_W-2:0], div_ge};

    // address, wrapped to ADDR_BITS then cut to the port
    assign addr_sum  = phct_pkg::SUM_W'(r_base) + phct_pkg::SUM_W'(r_p2)
                     + phct_pkg::SUM_W'(r_samp);
    assign addr_wrap = phct_pkg::SUM_W'(addr_sum[AW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_count <= phct_pkg::CH_W'(1);
            r_ppb        <= phct_pkg::PPB_W'(1);
            r_wpos       <= '0;
            r_div_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    phct_pkg::CFG_CHAN_COUNT: r_chan_count <= i_cfg_data;
                    phct_pkg::CFG_PPB:        r_ppb <= i_cfg_data[phct_pkg::PPB_W-1:0];
                endcase
            end
            if (i_cmd.take) begin
                r_wpos <= n_wpos;
            end
            if (i_cmd.take && pos_first) begin
                r_div_cnt <= div_trivial ? '0 : phct_pkg::DIV_CNT_W'(phct_pkg::DIV_STEPS);
            end else if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_cap_ch  <= n_cap_ch;
            r_cap_sub <= n_cap_sub;
            r_cap_ts  <= n_cap_ts;
            r_res     <= n_res;
            if (pos_first) begin
                r_spp <= '0;
                r_cc  <= '0;
                r_sc  <= '0;
                r_quo <= len_body[phct_pkg::LEN_W-1:2];
                r_rem <= '0;
                r_den <= r_chan_count;
            end else if (pos_three) begin
                r_base <= phct_pkg::BASE_W'(i_bidx) * phct_pkg::BASE_W'(r_spp);
            end else if (!pos_header) begin
                r_p1   <= phct_pkg::P1_W'(r_cc) * phct_pkg::P1_W'(r_ppb);
                r_samp <= r_sc;
                r_cc   <= n_cc;
                r_sc   <= n_sc;
            end
        end
        if (r_div_cnt != '0) begin
            r_quo <= n_quo;
            r_rem <= div_ge ? rem_sub[phct_pkg::CH_W-1:0] : rem_sh[phct_pkg::CH_W-1:0];
            if (r_div_cnt == phct_pkg::DIV_CNT_W'(1)) begin
                // saturate the quotient to 12 bits
                r_spp <= n_quo[phct_pkg::DIVIDEND_W-1] ? phct_pkg::SAT12
                                                        : n_quo[phct_pkg::CNT_W-1:0];
            end
        end
        if (i_cmd.mul_step) begin
            r_p2 <= phct_pkg::P2_W'(r_p1) * phct_pkg::P2_W'(r_spp);
        end
        if (i_cmd.sum_step && (r_res.kind == phct_pkg::KIND_PLACED)) begin
            r_res.address <= addr_wrap[phct_pkg::ADDR_OUT_W-1:0];
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    assign o_stat.pos_first  = pos_first;
    assign o_stat.pos_header = pos_header;
    assign o_stat.hdr_result = pos_three || i_last;
    assign o_stat.div_busy   = (r_div_cnt != '0);
    assign o_stat.last_word  = r_res.last_of_packet;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_div_idle_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |-> (r_div_cnt == '0))
        else $error("word taken while divider busy");

    a_surplus_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind != phct_pkg::KIND_PLACED)) |-> (r_out.address == '0))
        else $error("address set on non-placed result");

    a_header_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == phct_pkg::KIND_HEADER) && !r_out.header_valid)
        |-> (r_out.sequence_res == '0))
        else $error("sequence number on invalid header");

endmodule

FILE: rtl/core/phct_ctrl.sv
// Controller: sequences take, divide, address products and result hand-off.
// Depends on phct_pkg.
module phct_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  phct_pkg::t_stat i_stat,
    output phct_pkg::t_cmd  o_cmd
);

    phct_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= phct_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            phct_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.take = i_valid;
                if (i_valid) begin
                    priority if (i_stat.pos_first) begin
                        n_state = phct_pkg::ST_DIV;
                    end else if (i_stat.pos_header) begin
                        n_state = i_stat.hdr_result ? phct_pkg::ST_EMIT : phct_pkg::ST_IDLE;
                    end else begin
                        n_state = phct_pkg::ST_MUL;
                    end
                end
            end
            phct_pkg::ST_DIV: begin
                // hold until spp is known; a one-word packet still reports its header
                if (!i_stat.div_busy) begin
                    n_state = i_stat.last_word ? phct_pkg::ST_EMIT : phct_pkg::ST_IDLE;
                end
            end
            phct_pkg::ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_state        = phct_pkg::ST_SUM;
            end
            phct_pkg::ST_SUM: begin
                o_cmd.sum_step = 1'b1;
                n_state        = phct_pkg::ST_EMIT;
            end
            phct_pkg::ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = phct_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = phct_pkg::ST_IDLE;
            end
        endcase
    end

    a_first_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_stat.pos_first) |=> (r_state == phct_pkg::ST_DIV))
        else $error("header word 0 did not start the divide");

    a_payload_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == phct_pkg::ST_MUL) |=> (r_state == phct_pkg::ST_SUM) ##1
        (r_state == phct_pkg::ST_EMIT))
        else $error("payload address sequence broken");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (i_stat.out_free && !i_stat.div_busy))
        else $error("result moved into a full output register");

endmodule

FILE: rtl/core/packet_header_parse_corner_turn.sv
// Top level of the packet header parser with corner-turn addressing.
// Depends on phct_pkg, phct_word_if, phct_res_if, phct_ctrl, phct_dpath.
//
//   port        dir   handshake     carries
//   i_word      in    valid/ready   word, packet_length, block_index, last
//   o_res       out   valid/ready   kind, header fields, sample, address, last_of_packet
//   i_cfg_*     in    write enable  chan_count (index 0), packets per block (index 1)
//
// Header word 0 is taken, then the block waits in the divide state while the 13-step
// restoring divider finds spp; the divider steps are skipped when the length is under 16 or
// chan_count is zero. Header words 1 and 2 are only taken; word 3 adds the hand-off,
// as does any header word with last set. Each payload word passes through take,
// channel*ppb*spp as two registered products, address add and hand-off.
// The next word is taken while a finished result waits in the output register;
// a stalled output holds the block in its hand-off state.
// Reset is synchronous, active low; no clearing pass is needed.
module packet_header_parse_corner_turn #(
    parameter int unsigned ADDR_BITS = phct_pkg::ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    phct_word_if.sink                         i_word,
    phct_res_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [phct_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [phct_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    phct_pkg::t_cmd    cmd;
    phct_pkg::t_stat   stat;
    phct_pkg::t_result out_res;

    phct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_word.valid),
        .o_ready (i_word.ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    phct_dpath #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_word      (i_word.word),
        .i_len       (i_word.packet_length),
        .i_bidx      (i_word.block_index),
        .i_last      (i_word.last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_out       (out_res)
    );

    assign o_res.kind           = out_res.kind;
    assign o_res.header_valid   = out_res.header_valid;
    assign o_res.channels       = out_res.channels;
    assign o_res.subpackets     = out_res.subpackets;
    assign o_res.timestamp      = out_res.timestamp;
    assign o_res.sequence_res   = out_res.sequence_res;
    assign o_res.sample         = out_res.sample;
    assign o_res.address        = out_res.address;
    assign o_res.last_of_packet = out_res.last_of_packet;

endmodule
